// ===== rtl/core/wheel_speed_pid_drive_unit_assert.svh =====
// Assertion macros for the wheel speed PID drive unit.
// Used by the top level; no other dependencies.
`ifndef WHEEL_SPEED_PID_DRIVE_UNIT_ASSERT_SVH
`define WHEEL_SPEED_PID_DRIVE_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define WSP_ASSERT_IMP(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication
`define WSP_ASSERT_NXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/wsp_pkg.sv =====
// Shared types and constants of the wheel speed PID drive unit.
// No dependencies.
`default_nettype none
package wsp_pkg;
   localparam int WHEEL_COUNT = 2;
   localparam int WHEEL_BITS = 1;
   localparam int COUNTER_BITS = 24;
   // counter wrap limit and the window on each side of the wrap point
   localparam logic [COUNTER_BITS-1:0] COUNT_LIM = '1;
   localparam logic [COUNTER_BITS-1:0] COUNT_WIN = COUNT_LIM >> 2;
   localparam logic [22:0] SPEED_SCALE = 23'd4117748;
   localparam logic [19:0] DRIVE_STOP = 20'd524288;
   localparam logic [19:0] DRIVE_MIN = 20'd256;
   localparam logic [19:0] DRIVE_MAX = 20'd1048320;
   localparam logic [1:0] REG_GAIN_P = 2'd0;
   localparam logic [1:0] REG_GAIN_I = 2'd1;
   localparam logic [1:0] REG_GAIN_D = 2'd2;
   localparam logic [1:0] REG_LIMIT = 2'd3;

   typedef struct packed {
      logic [WHEEL_BITS-1:0] wheel;
      logic signed [31:0] target_speed;
      logic [COUNTER_BITS-1:0] encoder_count;
      logic [39:0] time_us;
   } req_type;

   typedef struct packed {
      logic [WHEEL_BITS-1:0] wheel_out;
      logic [11:0] drive_value;
      logic signed [31:0] measured_speed;
   } rsp_type;

   // divider control and status
   typedef struct packed {
      logic start;
      logic [63:0] dividend;
      logic [39:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [63:0] quotient;
   } div_sts_type;
endpackage
`default_nettype wire

// ===== rtl/core/wsp_if.sv =====
// Valid/ready channel interface carrying a request or result payload.
// Depends on wsp_pkg for the payload types.
`default_nettype none
interface wsp_req_if;
   logic valid;
   logic ready;
   wsp_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface wsp_rsp_if;
   logic valid;
   logic ready;
   wsp_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wheel_speed_pid_drive_unit.sv =====
// Wheel speed PID drive unit: per-wheel encoder speed estimate and PID drive;
// uses wsp_pkg, wsp_if, wsp_divider and the assertion header.
// Runs two divisions on the shared divider when time advances, none otherwise;
// one request at a time, taken again once the unit is back in idle, which is
// delayed while an earlier result still waits.
// Sync active-high reset restores gains, clears history, accumulators to 2048.0.
`default_nettype none
`include "wheel_speed_pid_drive_unit_assert.svh"
module wheel_speed_pid_drive_unit (
   input  wire logic clock,
   input  wire logic reset,
   wsp_req_if.sink req,
   wsp_rsp_if.source rsp,
   input  wire logic csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [30:0] csr_write_data
);
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DELTA  = 9'b000000010,
      ST_DIV1   = 9'b000000100,
      ST_SPEED  = 9'b000001000,
      ST_DIV2   = 9'b000010000,
      ST_ACCEL  = 9'b000100000,
      ST_MUL    = 9'b001000000,
      ST_ACCUM  = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic signed [15:0] gp_ff, gi_ff, gd_ff;
   logic [30:0] lim_ff;
   logic [wsp_pkg::COUNTER_BITS-1:0] last_count_ff [wsp_pkg::WHEEL_COUNT];
   logic [39:0] last_time_ff [wsp_pkg::WHEEL_COUNT];
   logic signed [31:0] last_speed_ff [wsp_pkg::WHEEL_COUNT];
   logic signed [32:0] integ_ff [wsp_pkg::WHEEL_COUNT];
   logic [19:0] accum_ff [wsp_pkg::WHEEL_COUNT];

   wsp_pkg::req_type cur_ff;
   logic signed [25:0] delta_ff;
   logic [39:0] dt_ff;
   logic timed_ff;
   logic signed [31:0] speed_ff, accel_ff;
   logic signed [33:0] err_ff;
   logic signed [49:0] corr_sum_ff;
   logic [1:0] mstep_ff;
   logic neg_ff;
   logic rsp_valid_ff;
   wsp_pkg::rsp_type rsp_ff;

   wsp_pkg::div_cmd_type div_cmd;
   wsp_pkg::div_sts_type div_sts;
   wsp_divider u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .sts(div_sts));

   logic [wsp_pkg::COUNTER_BITS-1:0] v0, v1;
   logic signed [25:0] dsel;
   logic [39:0] lt;
   logic signed [32:0] sdiff;
   logic [32:0] sdmag;
   logic signed [17:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [49:0] mul_p;
   logic signed [34:0] integ_sum, integ_c;
   logic signed [34:0] lim_s;
   logic signed [33:0] corr;
   logic signed [35:0] acc_s;
   logic [19:0] acc_c;
   logic [63:0] q;
   logic signed [64:0] sq;
   logic [wsp_pkg::WHEEL_BITS-1:0] w;

   assign w = cur_ff.wheel;
   assign v0 = last_count_ff[w];
   assign v1 = cur_ff.encoder_count;
   assign lt = last_time_ff[w];
   assign q = div_sts.quotient;
   // result register parts intake from a stalled receiver
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   // wrap-aware delta, sign flipped for wheel 0
   always_comb begin
      if (v0 > wsp_pkg::COUNT_LIM - wsp_pkg::COUNT_WIN && v1 < wsp_pkg::COUNT_WIN)
         dsel = 26'sd1 + $signed({2'b0, wsp_pkg::COUNT_LIM - v0}) + $signed({2'b0, v1});
      else if (v0 < wsp_pkg::COUNT_WIN && v1 > wsp_pkg::COUNT_LIM - wsp_pkg::COUNT_WIN)
         dsel = -(26'sd1 + $signed({2'b0, wsp_pkg::COUNT_LIM - v1}) + $signed({2'b0, v0}));
      else
         dsel = $signed({2'b0, v1}) - $signed({2'b0, v0});
      if (w != 1'b1) dsel = -dsel;
   end

   assign sdiff = $signed({speed_ff[31], speed_ff}) - $signed({last_speed_ff[w][31],
                  last_speed_ff[w]});
   assign sdmag = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
   assign sq = neg_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
   assign lim_s = $signed({4'b0, lim_ff});
   assign integ_sum = 35'(integ_ff[w]) + 35'(err_ff);
   assign integ_c = (integ_sum > lim_s) ? lim_s : ((integ_sum < -lim_s) ? -lim_s : integ_sum);

   // shared multiplier operand select
   always_comb begin
      unique case (mstep_ff)
         2'd0: begin mul_a = 18'(gp_ff); mul_b = err_ff; end
         2'd1: begin mul_a = 18'(gd_ff); mul_b = 34'(accel_ff); end
         default: begin mul_a = 18'(gi_ff); mul_b = 34'(integ_ff[w]); end
      endcase
      mul_p = 50'(mul_a) * 50'(mul_b);
   end

   assign corr = 34'(corr_sum_ff >>> 16);
   assign acc_s = (w == 1'b1) ? 36'(accum_ff[w]) - 36'(corr) : 36'(accum_ff[w]) + 36'(corr);
   assign acc_c = (cur_ff.target_speed == 0 && speed_ff == 0) ? wsp_pkg::DRIVE_STOP :
                  (acc_s < 36'sd256) ? wsp_pkg::DRIVE_MIN :
                  (acc_s > 36'sd1048320) ? wsp_pkg::DRIVE_MAX : acc_s[19:0];

   always_comb begin
      div_cmd = '0;
      div_cmd.divisor = dt_ff;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid && req.ready) state_in = ST_DELTA;
         ST_DELTA: state_in = (lt != 0 && cur_ff.time_us > lt) ? ST_DIV1 : ST_MUL;
         ST_DIV1: begin
            div_cmd.start = 1'b1;
            div_cmd.dividend = 64'(delta_ff[25] ? 26'(-delta_ff) : delta_ff) *
                               64'(wsp_pkg::SPEED_SCALE);
            state_in = ST_SPEED;
         end
         ST_SPEED: if (div_sts.done) state_in = ST_DIV2;
         ST_DIV2: begin
            div_cmd.start = 1'b1;
            div_cmd.dividend = 64'(sdmag) * 64'd1000000;
            state_in = ST_ACCEL;
         end
         ST_ACCEL: if (div_sts.done) state_in = ST_MUL;
         ST_MUL: if (mstep_ff == 2'd2) state_in = ST_ACCUM;
         // hold until the result register is free
         ST_ACCUM: state_in = rsp_valid_ff ? ST_ACCUM : ST_OUT;
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gp_ff <= 16'sd742;
         gi_ff <= 16'sd179;
         gd_ff <= -16'sd307;
         lim_ff <= 31'd131072;
         mstep_ff <= '0;
         for (int k = 0; k < wsp_pkg::WHEEL_COUNT; k++) begin
            last_count_ff[k] <= '0;
            last_time_ff[k] <= '0;
            last_speed_ff[k] <= '0;
            integ_ff[k] <= '0;
            accum_ff[k] <= wsp_pkg::DRIVE_STOP;
         end
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr_write_enable) begin
            unique case (csr_index)
               wsp_pkg::REG_GAIN_P: gp_ff <= csr_write_data[15:0];
               wsp_pkg::REG_GAIN_I: gi_ff <= csr_write_data[15:0];
               wsp_pkg::REG_GAIN_D: gd_ff <= csr_write_data[15:0];
               default: lim_ff <= csr_write_data;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: if (req.valid && req.ready) cur_ff <= req.data;
            ST_DELTA: begin
               delta_ff <= dsel;
               dt_ff <= cur_ff.time_us - lt;
               neg_ff <= dsel[25];
               speed_ff <= '0;
               accel_ff <= '0;
               last_count_ff[w] <= v1;
               mstep_ff <= '0;
               corr_sum_ff <= '0;
            end
            ST_SPEED: if (div_sts.done) begin
               speed_ff <= (sq > 65'sh7fffffff) ? 32'sh7fffffff :
                           (sq < -65'sh80000000) ? 32'sh80000000 : sq[31:0];
            end
            ST_DIV2: neg_ff <= sdiff[32];
            ST_ACCEL: if (div_sts.done) begin
               accel_ff <= (sq > 65'sh7fffffff) ? 32'sh7fffffff :
                           (sq < -65'sh80000000) ? 32'sh80000000 : sq[31:0];
            end
            // err, then integrator, then three multiply-accumulate steps
            ST_MUL: begin
               if (!timed_ff) begin
                  if (mstep_ff == 2'd0) begin
                     err_ff <= 34'(cur_ff.target_speed) - 34'(speed_ff);
                     mstep_ff <= 2'd3;
                  end else begin
                     integ_ff[w] <= 33'(integ_c);
                     mstep_ff <= 2'd0;
                  end
               end else begin
                  corr_sum_ff <= corr_sum_ff + mul_p;
                  mstep_ff <= mstep_ff + 2'd1;
               end
            end
            ST_ACCUM: if (!rsp_valid_ff) begin
               accum_ff[w] <= acc_c;
               last_time_ff[w] <= cur_ff.time_us;
               last_speed_ff[w] <= speed_ff;
               rsp_ff.wheel_out <= w;
               rsp_ff.drive_value <= acc_c[19:8];
               rsp_ff.measured_speed <= speed_ff;
            end
            ST_OUT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // timed_ff gates the multiply steps once err and integrator are settled
   always_ff @(posedge clock) begin
      if (reset) timed_ff <= 1'b0;
      else timed_ff <= (state_ff == ST_MUL) && (state_in == ST_MUL) &&
                       (timed_ff || mstep_ff == 2'd3);
   end

   `WSP_ASSERT_IMP(a_ready_idle, req.ready, state_ff == ST_IDLE)
   `WSP_ASSERT_NXT(a_accept_starts, req.valid && req.ready, state_ff == ST_DELTA)
   `WSP_ASSERT_IMP(a_div_idle, state_ff == ST_MUL, !div_sts.busy)
   `WSP_ASSERT_NXT(a_out_valid, state_ff == ST_OUT, rsp_valid_ff)
endmodule
`default_nettype wire

// ===== rtl/core/wsp_divider.sv =====
// Unsigned restoring divider, 64-bit dividend by 40-bit divisor, one bit a cycle.
// Depends on wsp_pkg.
`default_nettype none
module wsp_divider (
   input  wire logic clock,
   input  wire logic reset,
   input  wire wsp_pkg::div_cmd_type cmd,
   output wsp_pkg::div_sts_type sts
);
   logic [63:0] quot_ff, quot_in;
   logic [40:0] rem_ff, rem_in;
   logic [39:0] dvs_ff, dvs_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [40:0] trial;
   logic [40:0] shifted;

   // one quotient bit per step
   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[39:0], quot_ff[63]};
      trial = shifted - {1'b0, dvs_ff};
      if (cmd.start) begin
         quot_in = cmd.dividend;
         rem_in = '0;
         dvs_in = cmd.divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[40]) begin
            rem_in = trial;
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quotient = quot_ff;
endmodule
`default_nettype wire
